### sv/pis_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// pis_pkg: shared constants, types and state codes of the intercept solver
// no dependencies

package pis_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIR_BITS = 14;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam logic [31:0] MAX_LEAD_RST = 32'd3932160;

    typedef logic [2:0] t_status;

    localparam t_status ST_NONE = 3'd0;
    localparam t_status ST_QUAD = 3'd1;
    localparam t_status ST_NOROOT = 3'd2;
    localparam t_status ST_LINEAR = 3'd3;
    localparam t_status ST_DEGEN = 3'd4;

    typedef struct packed {
        logic             ok;
        logic [2:0][31:0] tg;
        logic [2:0][32:0] v;
        logic [2:0][31:0] sh;
        logic [63:0]      a;
        logic [63:0]      b;
        logic [63:0]      c;
    } t_job;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DIV_LIN,
        S_MUL_BB,
        S_MUL_AC,
        S_SQRT_D,
        S_DIV_R1,
        S_DIV_R2,
        S_CLAMP,
        S_MUL_V,
        S_DIFF,
        S_MUL_D,
        S_SQRT_L,
        S_DIV_DIR,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

### sv/pis_front.sv
`timescale 1ns / 1ps
`default_nettype none
// pis_front: three-stage pipeline forming velocity and the quadratic coefficients
// depends on pis_pkg

module pis_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_take,
    input  wire logic           i_target_valid,
    input  wire logic [31:0]    i_target_x,
    input  wire logic [31:0]    i_target_y,
    input  wire logic [31:0]    i_target_z,
    input  wire logic [31:0]    i_prior_x,
    input  wire logic [31:0]    i_prior_y,
    input  wire logic [31:0]    i_prior_z,
    input  wire logic [31:0]    i_shooter_x,
    input  wire logic [31:0]    i_shooter_y,
    input  wire logic [31:0]    i_shooter_z,
    input  wire logic [31:0]    i_projectile_speed,
    output logic                o_push,
    output pis_pkg::t_job       o_job
);
    import pis_pkg::*;

    logic [2:0][31:0] w_tg, w_pr, w_sh;
    logic [2:0][32:0] w_v, w_p;

    logic             r_s1_vld, r_s1_ok;
    logic [2:0][31:0] r_s1_tg, r_s1_sh;
    logic [2:0][32:0] r_s1_v;
    logic [2:0][30:0] r_s1_vs, r_s1_ps;
    logic [29:0]      r_s1_s;

    logic               r_s2_vld, r_s2_ok;
    logic [2:0][31:0]   r_s2_tg, r_s2_sh;
    logic [2:0][32:0]   r_s2_v;
    logic signed [61:0] r_s2_vv [3];
    logic signed [61:0] r_s2_pv [3];
    logic signed [61:0] r_s2_pp [3];
    logic [59:0]        r_s2_ss;

    logic  r_s3_vld;
    t_job  r_job;

    assign w_tg = {i_target_z, i_target_y, i_target_x};
    assign w_pr = {i_prior_z, i_prior_y, i_prior_x};
    assign w_sh = {i_shooter_z, i_shooter_y, i_shooter_x};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_v[i] = {w_tg[i][31], w_tg[i]} - {w_pr[i][31], w_pr[i]};
            w_p[i] = {w_tg[i][31], w_tg[i]} - {w_sh[i][31], w_sh[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_take;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    // stage 1: differences, floored by four
    always_ff @(posedge i_clk) begin
        r_s1_ok <= i_target_valid;
        r_s1_tg <= w_tg;
        r_s1_sh <= w_sh;
        r_s1_v  <= w_v;
        r_s1_s  <= i_projectile_speed[31:2];
        for (int i = 0; i < 3; i++) begin
            r_s1_vs[i] <= w_v[i][32:2];
            r_s1_ps[i] <= w_p[i][32:2];
        end
    end

    // stage 2: products
    always_ff @(posedge i_clk) begin
        r_s2_ok <= r_s1_ok;
        r_s2_tg <= r_s1_tg;
        r_s2_sh <= r_s1_sh;
        r_s2_v  <= r_s1_v;
        r_s2_ss <= r_s1_s * r_s1_s;
        for (int i = 0; i < 3; i++) begin
            r_s2_vv[i] <= $signed(r_s1_vs[i]) * $signed(r_s1_vs[i]);
            r_s2_pv[i] <= $signed(r_s1_ps[i]) * $signed(r_s1_vs[i]);
            r_s2_pp[i] <= $signed(r_s1_ps[i]) * $signed(r_s1_ps[i]);
        end
    end

    // stage 3: sums
    always_ff @(posedge i_clk) begin
        r_job.ok <= r_s2_ok;
        r_job.tg <= r_s2_tg;
        r_job.sh <= r_s2_sh;
        r_job.v  <= r_s2_v;
        r_job.a  <= 64'(r_s2_vv[0]) + 64'(r_s2_vv[1]) + 64'(r_s2_vv[2]) - 64'(r_s2_ss);
        r_job.b  <= 64'(r_s2_pv[0]) + 64'(r_s2_pv[1]) + 64'(r_s2_pv[2]);
        r_job.c  <= 64'(r_s2_pp[0]) + 64'(r_s2_pp[1]) + 64'(r_s2_pp[2]);
    end

    assign o_push = r_s3_vld;
    assign o_job  = r_job;

endmodule

`default_nettype wire

### sv/pis_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// pis_fifo: job queue between front and back, with credit count for the busy flag
// depends on pis_pkg

module pis_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_take,
    input  wire logic           i_push,
    input  wire pis_pkg::t_job  i_job,
    input  wire logic           i_pop,
    output pis_pkg::t_job       o_job,
    output logic                o_empty,
    output logic                o_busy
);
    import pis_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_cnt, r_credit;

    // credits cover jobs in the front pipeline as well as queued ones
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_rp     <= '0;
            r_cnt    <= '0;
            r_credit <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_cnt    <= r_cnt + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
            r_credit <= r_credit + (QPTR_W+1)'(i_take) - (QPTR_W+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    assign o_job   = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_busy  = (r_credit == (QPTR_W+1)'(QDEPTH));

endmodule

`default_nettype wire

### sv/pis_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// pis_mul: shift-add 64 x 64 multiplier, one multiplier bit per cycle
// depends on pis_pkg

module pis_mul (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_load,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic             o_done,
    output logic [127:0]     o_prod
);
    import pis_pkg::*;

    localparam int MW = 64;
    localparam int CW = $clog2(MW);

    logic [2*MW-1:0] r_a, r_acc;
    logic [MW-1:0]   r_b;
    logic [CW-1:0]   r_cnt;
    logic            r_busy, r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(MW-1));
            if (i_load) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(MW-1)) r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a   <= (2*MW)'(i_a);
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_b[0]) r_acc <= r_acc + r_a;
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

### sv/pis_div.sv
`timescale 1ns / 1ps
`default_nettype none
// pis_div: restoring divider, floor(num * 2^FRAC_BITS / den) saturated to 32 bits
// depends on pis_pkg

module pis_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_load,
    input  wire logic [63:0] i_num,
    input  wire logic [63:0] i_den,
    output logic             o_done,
    output logic [31:0]      o_q
);
    import pis_pkg::*;

    localparam int QW = 32;
    localparam int NW = 64;
    localparam int SH = QW - FRAC_BITS;
    localparam int CW = $clog2(QW);

    logic [NW-1:0] r_rem, r_den;
    logic [QW-1:0] r_x, r_q;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done, r_sat;
    logic [NW:0]   w_trial;
    logic          w_ge;

    assign w_trial = {r_rem, r_x[QW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(QW-1));
            if (i_load) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(QW-1)) r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sat <= ((NW+SH)'(i_num) >= ((NW+SH)'(i_den) << SH));
            r_rem <= i_num >> SH;
            r_x   <= {i_num[SH-1:0], FRAC_BITS'(0)};
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? NW'(w_trial - {1'b0, r_den}) : NW'(w_trial);
            r_x   <= r_x << 1;
            r_q   <= {r_q[QW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_q    = r_sat ? '1 : r_q;

endmodule

`default_nettype wire

### sv/pis_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// pis_sqrt: digit-by-digit integer square root of a 126-bit value, one bit per cycle
// depends on pis_pkg

module pis_sqrt (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_load,
    input  wire logic [127:0] i_x,
    output logic              o_done,
    output logic [62:0]       o_root
);
    import pis_pkg::*;

    localparam int RW = 63;
    localparam int XW = 2 * RW;
    localparam int CW = $clog2(RW);

    logic [XW-1:0] r_x;
    logic [RW+2:0] r_rem;
    logic [RW-1:0] r_root;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [RW+2:0] w_cur, w_trial;
    logic          w_ge;

    assign w_cur   = {r_rem[RW:0], r_x[XW-1:XW-2]};
    assign w_trial = (RW+3)'({r_root, 2'b01});
    assign w_ge    = (w_cur >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(RW-1));
            if (i_load) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(RW-1)) r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x    <= i_x[XW-1:0];
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= r_x << 2;
            r_rem  <= w_ge ? (w_cur - w_trial) : w_cur;
            r_root <= {r_root[RW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

### sv/pis_back.sv
`timescale 1ns / 1ps
`default_nettype none
// pis_back: sequencer that solves for intercept time, aim point and direction
// depends on pis_pkg, pis_mul, pis_div, pis_sqrt

module pis_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_empty,
    input  wire pis_pkg::t_job  i_job,
    input  wire logic [31:0]    i_max_lead,
    output logic                o_pop,
    output logic                o_done,
    output logic [2:0][31:0]    o_aim,
    output logic [2:0][15:0]    o_dir,
    output logic [31:0]         o_hit_time,
    output pis_pkg::t_status    o_status
);
    import pis_pkg::*;

    localparam int DIR_SH = FRAC_BITS - DIR_BITS;

    t_state           r_state, n_state;
    t_job             r_job, n_job;
    logic [127:0]     r_bb, n_bb;
    logic [65:0]      r_num1, n_num1, r_num2, n_num2;
    logic [31:0]      r_t1, n_t1, r_t, n_t;
    t_status          r_status, n_status;
    logic [1:0]       r_idx, n_idx;
    logic [2:0][31:0] r_aim, n_aim;
    logic [2:0][32:0] r_d, n_d;
    logic [65:0]      r_len2, n_len2;
    logic [2:0][15:0] r_dir, n_dir;

    logic         mul_load, mul_done;
    logic [63:0]  mul_a, mul_b;
    logic [127:0] mul_p;
    logic         div_load, div_done;
    logic [63:0]  div_num, div_den;
    logic [31:0]  div_q;
    logic         sq_load, sq_done;
    logic [127:0] sq_x;
    logic [62:0]  sq_root;

    logic [63:0]        w_absa, w_absb;
    logic [65:0]        w_b66, w_r66, w_num1, w_num2, w_len2_sum;
    logic               w_neg1, w_neg2;
    logic [31:0]        w_tc;
    logic [1:0]         w_idx_nx;
    logic signed [50:0] w_tg51, w_step51, w_sum;
    logic [31:0]        w_aim_new;
    logic [2:0][32:0]   w_d;
    logic [63:0]        w_dir_den;

    function automatic logic [63:0] f_mag33(input logic [32:0] x);
        logic [32:0] m;
        m = x[32] ? -x : x;
        return 64'(m);
    endfunction

    function automatic logic [63:0] f_mag66(input logic [65:0] x);
        return 64'(x[65] ? -x : x);
    endfunction

    pis_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (mul_load),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    pis_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (div_load),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    pis_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (sq_load),
        .i_x     (sq_x),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    assign w_absa   = r_job.a[63] ? -r_job.a : r_job.a;
    assign w_absb   = r_job.b[63] ? -r_job.b : r_job.b;
    assign w_b66    = {{2{r_job.b[63]}}, r_job.b};
    assign w_r66    = 66'(sq_root);
    assign w_num1   = -w_b66 - w_r66;
    assign w_num2   = w_r66 - w_b66;
    assign w_neg1   = (r_num1 != '0) && (r_num1[65] != r_job.a[63]);
    assign w_neg2   = (r_num2 != '0) && (r_num2[65] != r_job.a[63]);
    assign w_tc     = (r_t > i_max_lead) ? i_max_lead : r_t;
    assign w_idx_nx = r_idx + 2'd1;

    // aim = target + sign(v) * ((|v| * t) >> FRAC_BITS), saturated
    assign w_tg51   = 51'($signed(r_job.tg[r_idx]));
    assign w_step51 = $signed({1'b0, mul_p[FRAC_BITS +: 50]});
    assign w_sum    = r_job.v[r_idx][32] ? (w_tg51 - w_step51) : (w_tg51 + w_step51);

    always_comb begin
        if (w_sum > 51'sd2147483647) begin
            w_aim_new = 32'h7fff_ffff;
        end else if (w_sum < -51'sd2147483648) begin
            w_aim_new = 32'h8000_0000;
        end else begin
            w_aim_new = w_sum[31:0];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_d[i] = {r_aim[i][31], r_aim[i]} - {r_job.sh[i][31], r_job.sh[i]};
        end
    end

    assign w_len2_sum = r_len2 + mul_p[65:0];
    assign w_dir_den  = 64'(sq_root) << DIR_SH;

    always_comb begin
        n_state  = r_state;
        n_job    = r_job;
        n_bb     = r_bb;
        n_num1   = r_num1;
        n_num2   = r_num2;
        n_t1     = r_t1;
        n_t      = r_t;
        n_status = r_status;
        n_idx    = r_idx;
        n_aim    = r_aim;
        n_d      = r_d;
        n_len2   = r_len2;
        n_dir    = r_dir;
        o_pop    = 1'b0;
        mul_load = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        div_load = 1'b0;
        div_num  = '0;
        div_den  = '0;
        sq_load  = 1'b0;
        sq_x     = '0;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_job   = i_job;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_t   = '0;
                n_aim = '0;
                n_dir = '0;
                if (!r_job.ok) begin
                    n_status = ST_NONE;
                    n_state  = S_EMIT;
                end else if (r_job.a == '0) begin
                    if (r_job.b == '0) begin
                        n_status = ST_DEGEN;
                        n_state  = S_CLAMP;
                    end else begin
                        n_status = ST_LINEAR;
                        // root -C/(2b) is negative or zero unless b < 0
                        if (!r_job.b[63] || r_job.c == '0) begin
                            n_state = S_CLAMP;
                        end else begin
                            div_load = 1'b1;
                            div_num  = r_job.c;
                            div_den  = w_absb << 1;
                            n_state  = S_DIV_LIN;
                        end
                    end
                end else begin
                    mul_load = 1'b1;
                    mul_a    = w_absb;
                    mul_b    = w_absb;
                    n_state  = S_MUL_BB;
                end
            end
            S_DIV_LIN: begin
                if (div_done) begin
                    n_t     = div_q;
                    n_state = S_CLAMP;
                end
            end
            S_MUL_BB: begin
                if (mul_done) begin
                    n_bb     = mul_p;
                    mul_load = 1'b1;
                    mul_a    = w_absa;
                    mul_b    = r_job.c;
                    n_state  = S_MUL_AC;
                end
            end
            S_MUL_AC: begin
                if (mul_done) begin
                    if (r_job.a[63]) begin
                        sq_load  = 1'b1;
                        sq_x     = r_bb + mul_p;
                        n_status = ST_QUAD;
                        n_state  = S_SQRT_D;
                    end else if (r_bb >= mul_p) begin
                        sq_load  = 1'b1;
                        sq_x     = r_bb - mul_p;
                        n_status = ST_QUAD;
                        n_state  = S_SQRT_D;
                    end else begin
                        n_status = ST_NOROOT;
                        n_state  = S_CLAMP;
                    end
                end
            end
            S_SQRT_D: begin
                if (sq_done) begin
                    n_num1   = w_num1;
                    n_num2   = w_num2;
                    div_load = 1'b1;
                    div_num  = f_mag66(w_num1);
                    div_den  = w_absa;
                    n_state  = S_DIV_R1;
                end
            end
            S_DIV_R1: begin
                if (div_done) begin
                    n_t1     = div_q;
                    div_load = 1'b1;
                    div_num  = f_mag66(r_num2);
                    div_den  = w_absa;
                    n_state  = S_DIV_R2;
                end
            end
            S_DIV_R2: begin
                if (div_done) begin
                    if (w_neg1 && w_neg2) begin
                        n_t = '0;
                    end else if (w_neg1) begin
                        n_t = div_q;
                    end else if (w_neg2) begin
                        n_t = r_t1;
                    end else begin
                        n_t = (r_t1 < div_q) ? r_t1 : div_q;
                    end
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: begin
                n_t      = w_tc;
                n_idx    = '0;
                mul_load = 1'b1;
                mul_a    = f_mag33(r_job.v[0]);
                mul_b    = 64'(w_tc);
                n_state  = S_MUL_V;
            end
            S_MUL_V: begin
                if (mul_done) begin
                    n_aim[r_idx] = w_aim_new;
                    if (r_idx == 2'd2) begin
                        n_state = S_DIFF;
                    end else begin
                        n_idx    = w_idx_nx;
                        mul_load = 1'b1;
                        mul_a    = f_mag33(r_job.v[w_idx_nx]);
                        mul_b    = 64'(r_t);
                    end
                end
            end
            S_DIFF: begin
                n_d      = w_d;
                n_len2   = '0;
                n_idx    = '0;
                mul_load = 1'b1;
                mul_a    = f_mag33(w_d[0]);
                mul_b    = f_mag33(w_d[0]);
                n_state  = S_MUL_D;
            end
            S_MUL_D: begin
                if (mul_done) begin
                    n_len2 = w_len2_sum;
                    if (r_idx == 2'd2) begin
                        sq_load = 1'b1;
                        sq_x    = 128'(w_len2_sum);
                        n_state = S_SQRT_L;
                    end else begin
                        n_idx    = w_idx_nx;
                        mul_load = 1'b1;
                        mul_a    = f_mag33(r_d[w_idx_nx]);
                        mul_b    = f_mag33(r_d[w_idx_nx]);
                    end
                end
            end
            S_SQRT_L: begin
                if (sq_done) begin
                    if (sq_root == '0) begin
                        n_state = S_EMIT;
                    end else begin
                        n_idx    = '0;
                        div_load = 1'b1;
                        div_num  = f_mag33(r_d[0]);
                        div_den  = w_dir_den;
                        n_state  = S_DIV_DIR;
                    end
                end
            end
            S_DIV_DIR: begin
                if (div_done) begin
                    n_dir[r_idx] = r_d[r_idx][32] ? -div_q[15:0] : div_q[15:0];
                    if (r_idx == 2'd2) begin
                        n_state = S_EMIT;
                    end else begin
                        n_idx    = w_idx_nx;
                        div_load = 1'b1;
                        div_num  = f_mag33(r_d[w_idx_nx]);
                        div_den  = w_dir_den;
                    end
                end
            end
            S_EMIT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job    <= n_job;
        r_bb     <= n_bb;
        r_num1   <= n_num1;
        r_num2   <= n_num2;
        r_t1     <= n_t1;
        r_t      <= n_t;
        r_status <= n_status;
        r_idx    <= n_idx;
        r_aim    <= n_aim;
        r_d      <= n_d;
        r_len2   <= n_len2;
        r_dir    <= n_dir;
    end

    assign o_done     = (r_state == S_EMIT);
    assign o_aim      = r_aim;
    assign o_dir      = r_dir;
    assign o_hit_time = r_t;
    assign o_status   = r_status;

endmodule

`default_nettype wire

### sv/projectile_intercept_solver.sv
`timescale 1ns / 1ps
`default_nettype none
// projectile_intercept_solver: lead solver for a constant-velocity target; pis_pkg,
// pis_front, pis_fifo, pis_back; the serial multiplier, square root and divider set the
// time from start to o_done, which depends on the solve path (quadratic, no real root,
// linear, degenerate or linear root at zero, no target) and is shorter at zero length;
// the back solves one transaction at a time; start taken while busy low
// reset: queue empty, sequencer idle, max_lead_frames back to 60.0; o_done cannot stall

module projectile_intercept_solver (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        i_target_valid,
    input  wire logic [31:0] i_target_x,
    input  wire logic [31:0] i_target_y,
    input  wire logic [31:0] i_target_z,
    input  wire logic [31:0] i_prior_x,
    input  wire logic [31:0] i_prior_y,
    input  wire logic [31:0] i_prior_z,
    input  wire logic [31:0] i_shooter_x,
    input  wire logic [31:0] i_shooter_y,
    input  wire logic [31:0] i_shooter_z,
    input  wire logic [31:0] i_projectile_speed,
    output logic             o_done,
    output logic [31:0]      o_aim_x,
    output logic [31:0]      o_aim_y,
    output logic [31:0]      o_aim_z,
    output logic [15:0]      o_dir_x,
    output logic [15:0]      o_dir_y,
    output logic [15:0]      o_dir_z,
    output logic [31:0]      o_hit_time,
    output logic [2:0]       o_solve_status
);
    import pis_pkg::*;

    logic [31:0]      r_max_lead;
    logic             w_take, w_push, w_pop, w_empty, w_busy;
    t_job             w_job_in, w_job_out;
    logic [2:0][31:0] w_aim;
    logic [2:0][15:0] w_dir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_lead <= MAX_LEAD_RST;
        end else if (i_cfg_we) begin
            r_max_lead <= i_cfg_wdata;
        end
    end

    assign w_take = start && !w_busy;
    assign busy   = w_busy;

    pis_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_take             (w_take),
        .i_target_valid     (i_target_valid),
        .i_target_x         (i_target_x),
        .i_target_y         (i_target_y),
        .i_target_z         (i_target_z),
        .i_prior_x          (i_prior_x),
        .i_prior_y          (i_prior_y),
        .i_prior_z          (i_prior_z),
        .i_shooter_x        (i_shooter_x),
        .i_shooter_y        (i_shooter_y),
        .i_shooter_z        (i_shooter_z),
        .i_projectile_speed (i_projectile_speed),
        .o_push             (w_push),
        .o_job              (w_job_in)
    );

    pis_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_empty (w_empty),
        .o_busy  (w_busy)
    );

    pis_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (w_empty),
        .i_job      (w_job_out),
        .i_max_lead (r_max_lead),
        .o_pop      (w_pop),
        .o_done     (o_done),
        .o_aim      (w_aim),
        .o_dir      (w_dir),
        .o_hit_time (o_hit_time),
        .o_status   (o_solve_status)
    );

    assign o_aim_x = w_aim[0];
    assign o_aim_y = w_aim[1];
    assign o_aim_z = w_aim[2];
    assign o_dir_x = w_dir[0];
    assign o_dir_y = w_dir[1];
    assign o_dir_z = w_dir[2];

endmodule

`default_nettype wire

### bench/intercept_checker.sv
`timescale 1ns / 1ps
// intercept_checker: predicts each intercept solve from the accepted transaction and
// compares the strobed result fields in order; depends on pis_pkg
module intercept_checker
    import pis_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        i_target_valid,
    input  wire logic [31:0] i_target_x,
    input  wire logic [31:0] i_target_y,
    input  wire logic [31:0] i_target_z,
    input  wire logic [31:0] i_prior_x,
    input  wire logic [31:0] i_prior_y,
    input  wire logic [31:0] i_prior_z,
    input  wire logic [31:0] i_shooter_x,
    input  wire logic [31:0] i_shooter_y,
    input  wire logic [31:0] i_shooter_z,
    input  wire logic [31:0] i_projectile_speed,
    input  wire logic        o_done,
    input  wire logic [31:0] o_aim_x,
    input  wire logic [31:0] o_aim_y,
    input  wire logic [31:0] o_aim_z,
    input  wire logic [15:0] o_dir_x,
    input  wire logic [15:0] o_dir_y,
    input  wire logic [15:0] o_dir_z,
    input  wire logic [31:0] o_hit_time,
    input  wire logic [2:0]  o_solve_status,
    output int               o_errors,
    output int               o_pending
);

    typedef struct packed {
        logic [2:0][31:0] aim;
        logic [2:0][15:0] dir;
        logic [31:0]      hit;
        t_status          status;
    } t_solution;

    typedef logic signed [127:0] t_wide;

    t_solution   solutions_due[$];
    logic [31:0] lead_limit;

    function automatic logic [63:0] floor_sqrt(input logic [127:0] x);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] cc;
        r = '0;
        for (int k = 62; k >= 0; k--) begin
            c = r | (64'd1 << k);
            cc = {64'd0, c} * {64'd0, c};
            if (cc <= x) r = c;
        end
        return r;
    endfunction

    // {negative, saturated magnitude of num * 2^FRAC_BITS / den}
    function automatic logic [32:0] lead_root(input t_wide num, input t_wide den);
        logic [127:0] an;
        logic [127:0] ad;
        logic [127:0] q;
        if (num == 0) return '0;
        an = num < 0 ? -num : num;
        ad = den < 0 ? -den : den;
        q = (an << FRAC_BITS) / ad;
        return {(num < 0) != (den < 0), q > 128'hFFFFFFFF ? 32'hFFFFFFFF : q[31:0]};
    endfunction

    function automatic t_solution solve_intercept(
        input logic valid, input logic [2:0][31:0] tg, input logic [2:0][31:0] pr,
        input logic [2:0][31:0] sh, input logic [31:0] speed, input logic [31:0] limit);
        t_solution    res;
        t_wide        v[3];
        t_wide        vs[3];
        t_wide        ps[3];
        t_wide        s, qa, qb, qc, disc, r, stp, aimw, d[3];
        logic [127:0] len2, vmag;
        logic [63:0]  len;
        logic [32:0]  r1, r2;
        logic [31:0]  t;
        res = '0;
        if (!valid) return res;
        t = '0;
        s = $signed({98'd0, speed[31:2]});
        qa = -(s * s);
        qb = 0;
        qc = 0;
        for (int i = 0; i < 3; i++) begin
            v[i] = t_wide'($signed(tg[i])) - t_wide'($signed(pr[i]));
            vs[i] = v[i] >>> 2;
            ps[i] = (t_wide'($signed(tg[i])) - t_wide'($signed(sh[i]))) >>> 2;
            qa += vs[i] * vs[i];
            qb += ps[i] * vs[i];
            qc += ps[i] * ps[i];
        end
        if (qa == 0) begin
            if (qb == 0) begin
                res.status = ST_DEGEN;
            end else begin
                res.status = ST_LINEAR;
                r1 = lead_root(-qc, 2 * qb);
                t = r1[32] ? '0 : r1[31:0];
            end
        end else begin
            disc = qb * qb - qa * qc;
            if (disc < 0) begin
                res.status = ST_NOROOT;
            end else begin
                res.status = ST_QUAD;
                r = $signed({64'd0, floor_sqrt(disc)});
                r1 = lead_root(-qb - r, qa);
                r2 = lead_root(-qb + r, qa);
                if (r1[32] && r2[32]) t = '0;
                else if (r1[32]) t = r2[31:0];
                else if (r2[32]) t = r1[31:0];
                else t = r1[31:0] < r2[31:0] ? r1[31:0] : r2[31:0];
            end
        end
        if (t > limit) t = limit;
        len2 = '0;
        for (int i = 0; i < 3; i++) begin
            vmag = v[i] < 0 ? -v[i] : v[i];
            stp = $signed((vmag * {96'd0, t}) >> FRAC_BITS);
            aimw = t_wide'($signed(tg[i])) + (v[i] < 0 ? -stp : stp);
            if (aimw > 128'sd2147483647) aimw = 128'sd2147483647;
            if (aimw < -128'sd2147483648) aimw = -128'sd2147483648;
            res.aim[i] = aimw[31:0];
            d[i] = aimw - t_wide'($signed(sh[i]));
            len2 += d[i] * d[i];
        end
        len = floor_sqrt(len2);
        for (int i = 0; i < 3; i++) begin
            if (len != 0) begin
                vmag = d[i] < 0 ? -d[i] : d[i];
                vmag = (vmag << DIR_BITS) / {64'd0, len};
                res.dir[i] = d[i] < 0 ? -vmag[15:0] : vmag[15:0];
            end
        end
        res.hit = t;
        return res;
    endfunction

    assign o_pending = solutions_due.size();

    always @(posedge i_clk) begin
        t_solution exp_sol;
        if (!i_rst_n) begin
            lead_limit = MAX_LEAD_RST;
            solutions_due.delete();
            o_errors = 0;
        end else begin
            if (o_done) begin
                if (solutions_due.size() == 0) begin
                    $error("result with no transaction outstanding");
                    o_errors++;
                end else begin
                    exp_sol = solutions_due.pop_front();
                    if (o_aim_x !== exp_sol.aim[0]) begin
                        $error("aim_x expected %h got %h", exp_sol.aim[0], o_aim_x);
                        o_errors++;
                    end
                    if (o_aim_y !== exp_sol.aim[1]) begin
                        $error("aim_y expected %h got %h", exp_sol.aim[1], o_aim_y);
                        o_errors++;
                    end
                    if (o_aim_z !== exp_sol.aim[2]) begin
                        $error("aim_z expected %h got %h", exp_sol.aim[2], o_aim_z);
                        o_errors++;
                    end
                    if (o_dir_x !== exp_sol.dir[0]) begin
                        $error("dir_x expected %h got %h", exp_sol.dir[0], o_dir_x);
                        o_errors++;
                    end
                    if (o_dir_y !== exp_sol.dir[1]) begin
                        $error("dir_y expected %h got %h", exp_sol.dir[1], o_dir_y);
                        o_errors++;
                    end
                    if (o_dir_z !== exp_sol.dir[2]) begin
                        $error("dir_z expected %h got %h", exp_sol.dir[2], o_dir_z);
                        o_errors++;
                    end
                    if (o_hit_time !== exp_sol.hit) begin
                        $error("hit_time expected %h got %h", exp_sol.hit, o_hit_time);
                        o_errors++;
                    end
                    if (o_solve_status !== exp_sol.status) begin
                        $error("solve_status expected %0d got %0d", exp_sol.status,
                               o_solve_status);
                        o_errors++;
                    end
                end
            end
            if (start && !busy) begin
                solutions_due.push_back(solve_intercept(i_target_valid,
                    {i_target_z, i_target_y, i_target_x},
                    {i_prior_z, i_prior_y, i_prior_x},
                    {i_shooter_z, i_shooter_y, i_shooter_x},
                    i_projectile_speed, lead_limit));
            end
            if (i_cfg_we) lead_limit = i_cfg_wdata;
        end
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// testbench: drives directed and random intercept transactions and lead limits
// into projectile_intercept_solver; depends on pis_pkg and intercept_checker
module testbench;
    import pis_pkg::*;

    localparam int CYCLE_LIMIT = 6000000;

    typedef struct packed {
        logic             valid;
        logic [2:0][31:0] tg;
        logic [2:0][31:0] pr;
        logic [2:0][31:0] sh;
        logic [31:0]      speed;
    } t_shot;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;
    t_shot       shot;
    logic        o_done;
    logic [31:0] o_aim_x, o_aim_y, o_aim_z, o_hit_time;
    logic [15:0] o_dir_x, o_dir_y, o_dir_z;
    logic [2:0]  o_solve_status;
    int          errors;
    int          pending;
    int          cycles;
    logic        no_idle;

    projectile_intercept_solver i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_target_valid(shot.valid),
        .i_target_x(shot.tg[0]), .i_target_y(shot.tg[1]), .i_target_z(shot.tg[2]),
        .i_prior_x(shot.pr[0]), .i_prior_y(shot.pr[1]), .i_prior_z(shot.pr[2]),
        .i_shooter_x(shot.sh[0]), .i_shooter_y(shot.sh[1]), .i_shooter_z(shot.sh[2]),
        .i_projectile_speed(shot.speed),
        .o_done(o_done), .o_aim_x(o_aim_x), .o_aim_y(o_aim_y), .o_aim_z(o_aim_z),
        .o_dir_x(o_dir_x), .o_dir_y(o_dir_y), .o_dir_z(o_dir_z),
        .o_hit_time(o_hit_time), .o_solve_status(o_solve_status)
    );

    intercept_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_target_valid(shot.valid),
        .i_target_x(shot.tg[0]), .i_target_y(shot.tg[1]), .i_target_z(shot.tg[2]),
        .i_prior_x(shot.pr[0]), .i_prior_y(shot.pr[1]), .i_prior_z(shot.pr[2]),
        .i_shooter_x(shot.sh[0]), .i_shooter_y(shot.sh[1]), .i_shooter_z(shot.sh[2]),
        .i_projectile_speed(shot.speed),
        .o_done(o_done), .o_aim_x(o_aim_x), .o_aim_y(o_aim_y), .o_aim_z(o_aim_z),
        .o_dir_x(o_dir_x), .o_dir_y(o_dir_y), .o_dir_z(o_dir_z),
        .o_hit_time(o_hit_time), .o_solve_status(o_solve_status),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    function automatic t_shot make_shot(input logic valid,
        input int tx, input int ty, input int tz, input int px, input int py, input int pz,
        input int sx, input int sy, input int sz, input logic [31:0] speed);
        t_shot s;
        s.valid = valid;
        s.tg = {tz, ty, tx};
        s.pr = {pz, py, px};
        s.sh = {sz, sy, sx};
        s.speed = speed;
        return s;
    endfunction

    function automatic int near(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic t_shot random_shot();
        t_shot s;
        int    kind, axis, q;
        kind = $urandom_range(0, 99);
        s.valid = 1'b1;
        for (int i = 0; i < 3; i++) begin
            s.tg[i] = near(1 << 26);
            s.pr[i] = s.tg[i] - near(1 << 18);
            s.sh[i] = near(1 << 26);
        end
        s.speed = $urandom_range(1 << 18, 1 << 21);
        if (kind < 15) begin
            // noise over the whole field range
            s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom};
            s.valid = kind < 5 ? 1'b0 : 1'b1;
        end else if (kind < 30) begin
            // projectile exactly as fast as the target
            axis = $urandom_range(0, 2);
            q = $urandom_range(1, 1 << 20);
            for (int i = 0; i < 3; i++) s.pr[i] = s.tg[i];
            s.pr[axis] = s.tg[axis] + ($urandom_range(0, 1) ? 4 * q : -4 * q);
            s.speed = 4 * q;
        end else if (kind < 33) begin
            for (int i = 0; i < 3; i++) s.pr[i] = s.tg[i];
            s.speed = $urandom_range(0, 3);
        end else if (kind < 45) begin
            s.speed = $urandom_range(0, 1 << 18);
        end
        return s;
    endfunction

    task automatic send(input t_shot s);
        start <= 1'b1;
        shot <= s;
        do @(posedge i_clk); while (busy);
        if (!no_idle && $urandom_range(0, 99) < 30) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [31:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [31:0] limits[5];
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        shot = '0;
        no_idle = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed transactions under the reset limit
        send(make_shot(0, -1, -1, -1, -1, -1, -1, -1, -1, -1, '1));
        send(make_shot(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send(make_shot(1, 5, 7, 9, 5, 7, 9, 5, 7, 9, 32'h10000));
        send(make_shot(1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                       32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 4));
        send(make_shot(1, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                       32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 32'h7FFFFFFF, '1));
        send(make_shot(1, 100 << 16, 0, 0, 110 << 16, 0, 0, 0, 0, 0, 1 << 20));
        send(make_shot(1, 100 << 16, 0, 0, 90 << 16, 0, 0, 0, 0, 0, 5 << 16));
        send(make_shot(1, 100 << 16, 0, 0, 110 << 16, 0, 0, 0, 0, 0, 5 << 16));
        send(make_shot(1, 4, 0, 0, -4, 0, 0, 0, 0, 0, 0));
        send(make_shot(1, 4, 0, 0, 12, 0, 0, 0, 0, 0, 0));
        send(make_shot(1, 0, 100 << 16, 0, 0, 104 << 16, 0, 0, 0, 0, 4 << 16));
        send(make_shot(1, 0, 100 << 16, 0, 0, 96 << 16, 0, 0, 0, 0, 4 << 16));
        send(make_shot(1, 0, 0, 1 << 30, 0, 0, 1 << 30, 0, 0, 0, 1 << 16));
        send(make_shot(1, 1 << 16, 2 << 16, 3 << 16, 1 << 16, 2 << 16, 3 << 16,
                       1 << 16, 2 << 16, 3 << 16, 0));
        send(make_shot(1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0,
                       32'h80000000, 32'h80000000, 32'h80000000, 0));
        drain();

        limits = '{32'd0, 32'hFFFFFFFF, 32'd5 << 16, 32'd1, $urandom};
        for (int phase = 0; phase < 5; phase++) begin
            write_limit(limits[phase]);
            if (phase == 1) begin
                send(make_shot(1, 100 << 16, 0, 0, 90 << 16, 0, 0, 0, 0, 0, 5 << 16));
                send(make_shot(1, 32'h7FFFFFFF, 0, 32'h80000000, 32'h80000000, 0,
                               32'h7FFFFFFF, 0, 0, 0, 8));
            end
            for (int n = 0; n < 270; n++) begin
                no_idle = (phase == 2);
                send(random_shot());
            end
            no_idle = 1'b0;
            drain();
        end

        if (errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
